// ===== hw/rtl/bsfc_pkg.sv =====
`default_nettype none

package bsfc_pkg;

    // Item layout
    localparam int COUNT_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int TORQUE_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 112;  // 32 + 5 * 16, already whole bytes
    localparam int M_DATA_W  = 40;   // 2 + 32, padded to 5 bytes

    // Configuration registers
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_ADDR_W = 4;

    localparam logic [REG_IDX_W-1:0] REG_INT_DECAY     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INT_TILT_RATE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INT_WHEEL     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INT_SPEED_REF = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUT_INTEGRAL  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OUT_TILT      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OUT_TILT_RATE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OUT_WHEEL     = 3'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TORQUE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LAG    = 2'd2;

    // Datapath widths: 16x32 product, sum of four products, magnitude of that sum
    localparam int PROD_W = GAIN_W + COUNT_W;   // 48
    localparam int ACC_W  = PROD_W + 1;         // 49
    localparam int MAG_W  = PROD_W;             // 48

    // Shared divider: divisor covers both schedule interval and fixed-point scale
    localparam int DIVR_W    = 17;
    localparam int DIV_STEPS = 4;
    localparam int DIV_ITER  = MAG_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    localparam logic DIV_SEL_MOD   = 1'b0;
    localparam logic DIV_SEL_SCALE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_MAC,
        S_DIVGO,
        S_SCALE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                 load_in;
        logic                 div_go;
        logic                 div_sel;
        logic                 mac_clr;
        logic                 mac_issue;
        logic                 mac_add;
        logic [REG_IDX_W-1:0] gain_idx;
        logic                 set_res;
        logic [STATUS_W-1:0]  res_code;
        logic                 integ_wr;
        logic                 rec_run;
        logic                 out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic run_ok;
        logic lag;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/balance_state_feedback_ctrl.sv =====
// Balance state-feedback controller with integral action.
//
// s_ channel: one control tick per transfer (tick count plus measured states).
// m_ channel: exactly one result per tick: status and total torque (each motor
//   takes half). Torque is zero unless status is "torque computed".
// cfg_ channel: gain writes, index 0..7; higher indexes are ignored. cfg_ready
//   is always high. Write only while no tick is in flight.
// Ticks are taken one at a time; s_tready is high only while idle.
// Accept to m_tvalid: a tick that does not run the controller takes one division
//   of the count by RUN_INTERVAL; a tick that runs it also takes two passes of
//   four multiply-accumulates on the one 16x32 multiplier, each followed by a
//   division by FIXED_SCALE on the same radix-16 divider. The next tick is
//   taken the cycle after the result is loaded.
// Reset (aresetn low, synchronous) clears gains, integral state, last run
//   count and the output valid flag.
// A stalled receiver holds the finished result in the output register; the
//   next tick is still accepted and worked on, and only its result waits until
//   the register is free.

`default_nettype none

module balance_state_feedback_ctrl #(
    parameter int RUN_INTERVAL = 4,
    parameter int FIXED_SCALE  = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // [31:0] tick_count, [47:32] tilt_angle, [63:48] tilt_rate,
    // [79:64] left_wheel_rate, [95:80] right_wheel_rate, [111:96] speed_reference
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [bsfc_pkg::S_DATA_W-1:0]       s_tdata,
    // [1:0] status, [33:2] torque, [39:34] zero
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bsfc_pkg::M_DATA_W-1:0]            m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bsfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bsfc_pkg::GAIN_W-1:0]         cfg_data
);

    bsfc_pkg::cmd_t cmd;
    bsfc_pkg::sts_t sts;

    // Gains can be written at any cycle
    assign cfg_ready = 1'b1;

    // Sequencer: schedule test, MAC passes, divider use, result transfer
    bsfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Gains, state, multiplier, accumulator, divider and output register
    bsfc_datapath #(
        .RUN_INTERVAL (RUN_INTERVAL),
        .FIXED_SCALE  (FIXED_SCALE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bsfc_div.sv =====
`default_nettype none

// Unsigned restoring divider, DIV_STEPS quotient bits per cycle.
module bsfc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [bsfc_pkg::MAG_W-1:0]    dividend,
    input  wire logic [bsfc_pkg::DIVR_W-1:0]   divisor,
    output logic                               done,
    output logic [bsfc_pkg::MAG_W-1:0]         quotient,
    output logic [bsfc_pkg::DIVR_W-1:0]        remainder
);

    localparam int MW = bsfc_pkg::MAG_W;
    localparam int DW = bsfc_pkg::DIVR_W;

    logic [MW-1:0]                    quo_reg, quo_next;
    logic [DW-1:0]                    rem_reg, rem_next;
    logic [bsfc_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [DW:0]                      trial;
    logic [MW-1:0]                    q_step;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        q_step   = '0;
        for (int i = 0; i < bsfc_pkg::DIV_STEPS; i++) begin
            trial  = {rem_next, quo_next[MW-1]};
            q_step = {quo_next[MW-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                trial     = trial - {1'b0, divisor};
                q_step[0] = 1'b1;
            end
            rem_next = trial[DW-1:0];
            quo_next = q_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bsfc_pkg::DIV_CNT_W'(bsfc_pkg::DIV_ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bsfc_datapath.sv =====
`default_nettype none

module bsfc_datapath #(
    parameter int RUN_INTERVAL = 4,
    parameter int FIXED_SCALE  = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire bsfc_pkg::cmd_t                       cmd,
    output bsfc_pkg::sts_t                            sts,
    input  wire logic [bsfc_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [bsfc_pkg::M_DATA_W-1:0]             m_tdata,
    input  wire logic                                 cfg_valid,
    input  wire logic                                 cfg_ready,
    input  wire logic [bsfc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [bsfc_pkg::GAIN_W-1:0]          cfg_data
);

    localparam int CW  = bsfc_pkg::COUNT_W;
    localparam int SW  = bsfc_pkg::SAMPLE_W;
    localparam int TW  = bsfc_pkg::TORQUE_W;
    localparam int PW  = bsfc_pkg::PROD_W;
    localparam int AW  = bsfc_pkg::ACC_W;
    localparam int MW  = bsfc_pkg::MAG_W;
    localparam int DW  = bsfc_pkg::DIVR_W;
    localparam int STW = bsfc_pkg::STATUS_W;

    // Input item fields
    logic        [CW-1:0] in_count;
    logic signed [SW-1:0] in_tilt, in_trate, in_left, in_right, in_vref;
    logic signed [SW:0]   wheel_sum;
    logic signed [SW-1:0] wheel_avg;

    assign in_count = s_tdata[CW-1:0];
    assign in_tilt  = s_tdata[CW+SW-1   -: SW];
    assign in_trate = s_tdata[CW+2*SW-1 -: SW];
    assign in_left  = s_tdata[CW+3*SW-1 -: SW];
    assign in_right = s_tdata[CW+4*SW-1 -: SW];
    assign in_vref  = s_tdata[CW+5*SW-1 -: SW];

    // Truncate toward zero: bias negative sums by one before the shift
    assign wheel_sum = (SW+1)'(in_left) + (SW+1)'(in_right);
    always_comb begin
        logic signed [SW:0] biased;
        biased    = wheel_sum + (SW+1)'(wheel_sum[SW]);
        wheel_avg = SW'(biased >>> 1);
    end

    logic        [CW-1:0] count_reg;
    logic signed [SW-1:0] tilt_reg, trate_reg, avg_reg, vref_reg;
    logic        [CW-1:0] last_reg;
    logic signed [TW-1:0] integ_reg;
    logic        [SW-1:0] gain_reg [bsfc_pkg::NUM_REGS];

    // Gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bsfc_pkg::NUM_REGS; i++) begin
                gain_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready &&
                     cfg_addr < bsfc_pkg::CFG_ADDR_W'(bsfc_pkg::NUM_REGS)) begin
            gain_reg[cfg_addr[bsfc_pkg::REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            count_reg <= in_count;
            tilt_reg  <= in_tilt;
            trate_reg <= in_trate;
            avg_reg   <= wheel_avg;
            vref_reg  <= in_vref;
        end
    end

    // Divider and its operands
    logic          div_done;
    logic [MW-1:0] div_quo;
    logic [DW-1:0] div_rem;
    logic [MW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic signed [AW-1:0] acc_reg;
    logic          neg_reg;
    logic [AW-1:0] acc_mag;

    assign acc_mag = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);

    always_comb begin
        if (cmd.div_sel == bsfc_pkg::DIV_SEL_SCALE) begin
            div_dividend = acc_mag[MW-1:0];
            div_divisor  = DW'(FIXED_SCALE);
        end else begin
            div_dividend = MW'(in_count);
            div_divisor  = DW'(RUN_INTERVAL);
        end
    end

    bsfc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (cmd.div_go) begin
            neg_reg <= acc_reg[AW-1];
        end
    end

    // Signed, saturated quotient
    logic [TW-1:0] sat_q;
    always_comb begin
        if (!neg_reg) begin
            sat_q = (|div_quo[MW-1:TW-1]) ? {1'b0, {(TW-1){1'b1}}} : div_quo[TW-1:0];
        end else if ((|div_quo[MW-1:TW]) || (div_quo[TW-1] && |div_quo[TW-2:0])) begin
            sat_q = {1'b1, {(TW-1){1'b0}}};
        end else begin
            sat_q = TW'(-div_quo[TW-1:0]);
        end
    end

    // Multiply-accumulate
    logic signed [SW-1:0] mul_gain;
    logic signed [TW-1:0] mul_opnd;
    logic signed [PW-1:0] prod_reg;

    assign mul_gain = gain_reg[cmd.gain_idx];

    always_comb begin
        case (cmd.gain_idx)
            bsfc_pkg::REG_INT_DECAY:     mul_opnd = integ_reg;
            bsfc_pkg::REG_INT_TILT_RATE: mul_opnd = TW'(trate_reg);
            bsfc_pkg::REG_INT_WHEEL:     mul_opnd = TW'(avg_reg);
            bsfc_pkg::REG_INT_SPEED_REF: mul_opnd = TW'(vref_reg);
            bsfc_pkg::REG_OUT_INTEGRAL:  mul_opnd = integ_reg;
            bsfc_pkg::REG_OUT_TILT:      mul_opnd = TW'(tilt_reg);
            bsfc_pkg::REG_OUT_TILT_RATE: mul_opnd = TW'(trate_reg);
            bsfc_pkg::REG_OUT_WHEEL:     mul_opnd = TW'(avg_reg);
            default:                     mul_opnd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_issue) begin
            prod_reg <= PW'(mul_gain) * PW'(mul_opnd);
        end
        if (cmd.mac_clr) begin
            acc_reg <= '0;
        end else if (cmd.mac_add) begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    // Controller state: integral and last run count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            last_reg  <= '0;
        end else begin
            if (cmd.integ_wr) begin
                integ_reg <= sat_q;
            end
            if (cmd.load_in && in_count == '0) begin
                last_reg <= '0;
            end else if (cmd.rec_run) begin
                last_reg <= count_reg;
            end
        end
    end

    // Result and output register
    logic [STW-1:0] res_status_reg, out_status_reg;
    logic [TW-1:0]  res_torque_reg, out_torque_reg;
    logic           m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_code;
            res_torque_reg <= (cmd.res_code == bsfc_pkg::ST_TORQUE) ? sat_q : '0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_torque_reg <= res_torque_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(bsfc_pkg::M_DATA_W - TW - STW){1'b0}}, out_torque_reg, out_status_reg};

    assign sts.div_done = div_done;
    assign sts.run_ok   = (div_rem == '0) && (count_reg != last_reg);
    assign sts.lag      = (count_reg - last_reg) > CW'(RUN_INTERVAL);
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

// ===== hw/rtl/bsfc_ctrl.sv =====
`default_nettype none

module bsfc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire bsfc_pkg::sts_t  sts,
    output bsfc_pkg::cmd_t       cmd
);

    localparam logic [2:0] LAST_K = 3'd4;

    bsfc_pkg::state_t state_reg, state_next;
    logic [2:0]       k_reg, k_next;
    logic             phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsfc_pkg::S_IDLE;
            k_reg     <= '0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.gain_idx = {phase_reg, k_reg[1:0]};
        s_tready   = 1'b0;

        case (state_reg)
            bsfc_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = bsfc_pkg::DIV_SEL_MOD;
                    state_next  = bsfc_pkg::S_MOD;
                end
            end
            bsfc_pkg::S_MOD: begin
                if (sts.div_done) begin
                    if (!sts.run_ok) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = bsfc_pkg::ST_NONE;
                        state_next   = bsfc_pkg::S_OUT;
                    end else if (sts.lag) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = bsfc_pkg::ST_LAG;
                        state_next   = bsfc_pkg::S_OUT;
                    end else begin
                        cmd.mac_clr = 1'b1;
                        k_next      = '0;
                        phase_next  = 1'b0;
                        state_next  = bsfc_pkg::S_MAC;
                    end
                end
            end
            bsfc_pkg::S_MAC: begin
                // product k issued while product k-1 is accumulated
                cmd.mac_issue = (k_reg != LAST_K);
                cmd.mac_add   = (k_reg != '0);
                k_next        = k_reg + 1'b1;
                if (k_reg == LAST_K) begin
                    state_next = bsfc_pkg::S_DIVGO;
                end
            end
            bsfc_pkg::S_DIVGO: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = bsfc_pkg::DIV_SEL_SCALE;
                state_next  = bsfc_pkg::S_SCALE;
            end
            bsfc_pkg::S_SCALE: begin
                cmd.div_sel = bsfc_pkg::DIV_SEL_SCALE;
                if (sts.div_done) begin
                    if (!phase_reg) begin
                        cmd.integ_wr = 1'b1;
                        cmd.mac_clr  = 1'b1;
                        k_next       = '0;
                        phase_next   = 1'b1;
                        state_next   = bsfc_pkg::S_MAC;
                    end else begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = bsfc_pkg::ST_TORQUE;
                        cmd.rec_run  = 1'b1;
                        state_next   = bsfc_pkg::S_OUT;
                    end
                end
            end
            bsfc_pkg::S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = bsfc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bsfc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsfc_checker.sv =====
`default_nettype none

module bsfc_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [bsfc_pkg::M_DATA_W-1:0]       m_tdata
);

    logic [bsfc_pkg::STATUS_W-1:0] st;
    assign st = m_tdata[bsfc_pkg::STATUS_W-1:0];

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One tick at a time: no accept in the cycle after an accept
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second tick accepted while busy");

    // Status is a defined code
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st == bsfc_pkg::ST_NONE || st == bsfc_pkg::ST_TORQUE ||
                     st == bsfc_pkg::ST_LAG)
        else $error("undefined status code");

    // Torque only reported with a computed torque
    a_torque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != bsfc_pkg::ST_TORQUE |->
            m_tdata[bsfc_pkg::STATUS_W +: bsfc_pkg::TORQUE_W] == '0)
        else $error("nonzero torque without run");

endmodule

bind balance_state_feedback_ctrl bsfc_checker u_bsfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
